// File: hdl/nns_pkg.sv
// Shared types, widths and codes of the nearest-neighbor select and collide block.
`timescale 1ns / 1ps

package nns_pkg;

  localparam int DIST_W      = 34;
  localparam int COORD_W     = 16;
  localparam int INDEX_W     = 8;
  localparam int RANK_W      = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int MAX_AGENTS  = 256;

  localparam logic OP_QUERY     = 1'b0;
  localparam logic OP_CANDIDATE = 1'b1;

  localparam logic KIND_NEIGHBOR = 1'b0;
  localparam logic KIND_CRASH    = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_COLLISION_RADIUS_SQ = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAR_LIMIT_SQ        = 1'b1;

  localparam logic [DIST_W-1:0] COLLISION_RADIUS_SQ_RESET = 34'd25600;
  localparam logic [DIST_W-1:0] FAR_LIMIT_SQ_RESET        = 34'd460800000;

  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    dist_t              sq_dist;
    logic [INDEX_W-1:0] id;
    logic               valid;
  } slot_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic shift_up;
  } cell_ctrl_t;

endpackage

// File: hdl/nns_if.sv
// Handshake channels for points, results and register writes.
`timescale 1ns / 1ps

interface nns_point_if;
  import nns_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [INDEX_W-1:0]        point_index;
  logic                      point_alive;
  logic                      point_predator;
  logic                      last_point;

  modport source (output valid, operation, point_x, point_y, point_index, point_alive,
                  point_predator, last_point, input ready);
  modport sink (input valid, operation, point_x, point_y, point_index, point_alive,
                point_predator, last_point, output ready);
endinterface

interface nns_result_if;
  import nns_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [RANK_W-1:0]  rank;
  logic [INDEX_W-1:0] neighbor_index;
  logic [DIST_W-1:0]  dist_sq;
  logic               slot_valid;
  logic               last_result;

  modport source (output valid, kind, rank, neighbor_index, dist_sq, slot_valid, last_result,
                  input ready);
  modport sink (input valid, kind, rank, neighbor_index, dist_sq, slot_valid, last_result,
                output ready);
endinterface

interface nns_cfg_if;
  import nns_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [DIST_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/nns_dist.sv
// Two-stage squared-difference pipeline for the x and y coordinates.
`timescale 1ns / 1ps

module nns_dist (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [nns_pkg::COORD_W-1:0] point_x,
  input  logic signed [nns_pkg::COORD_W-1:0] point_y,
  input  logic signed [nns_pkg::COORD_W-1:0] self_x,
  input  logic signed [nns_pkg::COORD_W-1:0] self_y,
  output nns_pkg::dist_t                     sq_x,
  output nns_pkg::dist_t                     sq_y
);
  import nns_pkg::*;

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic [COORD_W:0]        ax;
  logic [COORD_W:0]        ay;

  assign dx = {point_x[COORD_W-1], point_x} - {self_x[COORD_W-1], self_x};
  assign dy = {point_y[COORD_W-1], point_y} - {self_y[COORD_W-1], self_y};

  always_ff @(posedge clk) begin
    if (en) begin
      ax   <= dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
      ay   <= dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
      sq_x <= DIST_W'(ax) * DIST_W'(ax);
      sq_y <= DIST_W'(ay) * DIST_W'(ay);
    end
  end

endmodule

// File: hdl/nns_cell.sv
// One slot of the sorted neighbor chain: load, compare, insert, shift down or drain up.
`timescale 1ns / 1ps

module nns_cell (
  input  logic                clk,
  input  logic                rst,
  input  nns_pkg::cell_ctrl_t ctrl,
  input  nns_pkg::dist_t      far_limit_sq,
  input  nns_pkg::slot_t      new_slot,
  input  nns_pkg::slot_t      prev_slot,
  input  logic                prev_lt,
  input  nns_pkg::slot_t      next_slot,
  output nns_pkg::slot_t      slot,
  output logic                lt
);
  import nns_pkg::*;

  assign lt = new_slot.sq_dist < slot.sq_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (ctrl.load) begin
      slot.sq_dist <= far_limit_sq;
      slot.id      <= '0;
      slot.valid   <= 1'b0;
    end else if (ctrl.shift_up) begin
      slot <= next_slot;
    end else if (ctrl.insert) begin
      if (prev_lt) begin
        slot <= prev_slot;
      end else if (lt) begin
        slot <= new_slot;
      end
    end
  end

endmodule

// File: hdl/nearest_neighbor_select_collide.sv
// Top level: point pipeline, neighbor cell chain, result register and registers.
// A taken candidate passes the registered point pipeline, then updates the chain.
// Throughput: one point beat per cycle, held off by a drain or a stalled crash.
// After the last candidate the list drains through cell 0 in NEIGHBORS result beats,
// and no point beat is taken during that drain; a crash result takes one beat.
// Reset is synchronous: registers return to their defaults and no query is open.
`timescale 1ns / 1ps

module nearest_neighbor_select_collide #(
  parameter int NEIGHBORS = 5
) (
  input  logic clk,
  input  logic rst,
  nns_point_if.sink    points,
  nns_result_if.source results,
  nns_cfg_if.sink      cfg
);
  import nns_pkg::*;

  localparam int CNT_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam logic [CNT_W-1:0] LAST_RANK = CNT_W'(NEIGHBORS - 1);

  dist_t collision_radius_sq;
  dist_t far_limit_sq;

  logic signed [COORD_W-1:0] self_x;
  logic signed [COORD_W-1:0] self_y;
  logic [INDEX_W-1:0]        self_id;
  logic                      self_pred;

  logic               v1, op1, skip1, prey1, last1;
  logic [INDEX_W-1:0] idx1;
  logic               v2, op2, skip2, prey2, last2;
  logic [INDEX_W-1:0] idx2;

  dist_t sq_x;
  dist_t sq_y;
  dist_t d;

  logic             query_open;
  logic             draining;
  logic [CNT_W-1:0] drain_rank;

  logic advance, accept, cand2, use2, crash;
  logic crash_fire, insert, close_last, load, drain_fire;

  logic               out_valid;
  logic               out_kind;
  logic [RANK_W-1:0]  out_rank;
  logic [INDEX_W-1:0] out_index;
  dist_t              out_dist;
  logic               out_slot_valid;
  logic               out_last;

  slot_t      new_slot;
  cell_ctrl_t ctrl;
  slot_t      slots     [NEIGHBORS];
  logic       lts       [NEIGHBORS];
  slot_t      prev_slot [NEIGHBORS];
  logic       prev_lt   [NEIGHBORS];
  slot_t      next_slot [NEIGHBORS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      collision_radius_sq <= COLLISION_RADIUS_SQ_RESET;
      far_limit_sq        <= FAR_LIMIT_SQ_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COLLISION_RADIUS_SQ: collision_radius_sq <= cfg.data;
        REG_FAR_LIMIT_SQ:        far_limit_sq        <= cfg.data;
        default: ;
      endcase
    end
  end

  assign d          = sq_x + sq_y;
  assign cand2      = v2 && (op2 == OP_CANDIDATE) && query_open;
  assign use2       = cand2 && !skip2;
  assign crash      = use2 && prey2 && (d < collision_radius_sq);
  assign advance    = !draining && !(crash && out_valid && !results.ready);
  assign accept     = points.valid && advance;
  assign crash_fire = crash && advance;
  assign insert     = use2 && !crash && advance;
  assign close_last = cand2 && last2 && !crash && advance;
  assign load       = v2 && (op2 == OP_QUERY) && advance;
  assign drain_fire = draining && (!out_valid || results.ready);

  assign points.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_x    <= '0;
      self_y    <= '0;
      self_id   <= '0;
      self_pred <= 1'b0;
    end else if (accept && (points.operation == OP_QUERY)) begin
      self_x    <= points.point_x;
      self_y    <= points.point_y;
      self_id   <= points.point_index;
      self_pred <= points.point_predator;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1   <= points.operation;
      idx1  <= points.point_index;
      skip1 <= !points.point_alive || (points.point_index == self_id) ||
               !(int'(points.point_index) < MAX_AGENTS);
      prey1 <= points.point_predator && !self_pred;
      last1 <= points.last_point;
      op2   <= op1;
      idx2  <= idx1;
      skip2 <= skip1;
      prey2 <= prey1;
      last2 <= last1;
    end
  end

  nns_dist u_dist (
    .clk     (clk),
    .en      (advance),
    .point_x (points.point_x),
    .point_y (points.point_y),
    .self_x  (self_x),
    .self_y  (self_y),
    .sq_x    (sq_x),
    .sq_y    (sq_y)
  );

  assign new_slot.sq_dist = d;
  assign new_slot.id      = idx2;
  assign new_slot.valid   = 1'b1;

  assign ctrl.load     = load;
  assign ctrl.insert   = insert;
  assign ctrl.shift_up = drain_fire;

  for (genvar i = 0; i < NEIGHBORS; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign prev_slot[i] = '0;
      assign prev_lt[i]   = 1'b0;
    end else begin : g_body
      assign prev_slot[i] = slots[i-1];
      assign prev_lt[i]   = lts[i-1];
    end
    if (i == NEIGHBORS - 1) begin : g_tail
      assign next_slot[i] = '0;
    end else begin : g_inner
      assign next_slot[i] = slots[i+1];
    end

    nns_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .far_limit_sq (far_limit_sq),
      .new_slot     (new_slot),
      .prev_slot    (prev_slot[i]),
      .prev_lt      (prev_lt[i]),
      .next_slot    (next_slot[i]),
      .slot         (slots[i]),
      .lt           (lts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_open <= 1'b0;
      draining   <= 1'b0;
      drain_rank <= '0;
    end else begin
      if (load) begin
        query_open <= 1'b1;
      end else if (crash_fire || close_last) begin
        query_open <= 1'b0;
      end
      if (close_last) begin
        draining   <= 1'b1;
        drain_rank <= '0;
      end else if (drain_fire) begin
        if (drain_rank == LAST_RANK) begin
          draining <= 1'b0;
        end
        drain_rank <= drain_rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (crash_fire || drain_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (crash_fire) begin
      out_kind       <= KIND_CRASH;
      out_rank       <= '0;
      out_index      <= idx2;
      out_dist       <= d;
      out_slot_valid <= 1'b1;
      out_last       <= 1'b1;
    end else if (drain_fire) begin
      out_kind       <= KIND_NEIGHBOR;
      out_rank       <= RANK_W'(drain_rank);
      out_index      <= slots[0].valid ? slots[0].id : '0;
      out_dist       <= slots[0].sq_dist;
      out_slot_valid <= slots[0].valid;
      out_last       <= (drain_rank == LAST_RANK);
    end
  end

  assign results.valid          = out_valid;
  assign results.kind           = out_kind;
  assign results.rank           = out_rank;
  assign results.neighbor_index = out_index;
  assign results.dist_sq        = out_dist;
  assign results.slot_valid     = out_slot_valid;
  assign results.last_result    = out_last;

  a_drain_blocks_points: assert property (@(posedge clk) disable iff (rst)
    close_last |=> draining && !points.ready)
    else $error("drain started without holding off point beats");

  a_single_source: assert property (@(posedge clk) disable iff (rst)
    crash_fire |-> !drain_fire)
    else $error("crash and ranked result loaded in the same cycle");

  a_crash_closes: assert property (@(posedge clk) disable iff (rst)
    crash_fire |=> !query_open && results.valid && results.last_result)
    else $error("crash result did not close the query");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (drain_fire && (drain_rank == LAST_RANK)) |=> !draining)
    else $error("drain ran past the last rank");

endmodule

// File: tb/nns_checker.sv
// Checker: predicts neighbor lists and crash results from point beats and compares result beats.
`timescale 1ns / 1ps

module nns_checker #(
  parameter int NEIGHBORS = 5
) (
  input  logic  clk,
  input  logic  rst,
  nns_point_if  points,
  nns_result_if results,
  nns_cfg_if    cfg,
  output int    errors,
  output int    pending
);
  import nns_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [RANK_W-1:0]  rank;
    logic [INDEX_W-1:0] id;
    dist_t              sq_dist;
    logic               valid;
    logic               last;
  } nn_result_t;

  dist_t                     radius_sq;
  dist_t                     far_sq;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic [INDEX_W-1:0]        query_id;
  logic                      query_pred;
  logic                      query_closed;
  slot_t                     nearest[NEIGHBORS];
  nn_result_t                expected_q[$];
  int                        fail_count = 0;

  assign errors = fail_count;

  task automatic report(string msg);
    $display("nns_checker: %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic dist_t squared_distance(logic signed [COORD_W-1:0] x,
                                             logic signed [COORD_W-1:0] y);
    longint dx;
    longint dy;
    dx = longint'(x) - longint'(query_x);
    dy = longint'(y) - longint'(query_y);
    return dist_t'(dx * dx + dy * dy);
  endfunction

  function void take_point();
    dist_t              d;
    logic [INDEX_W-1:0] idx;
    int                 i;
    int                 j;
    bit                 placed;
    idx = points.point_index;
    if (points.operation == OP_QUERY) begin
      query_x      = points.point_x;
      query_y      = points.point_y;
      query_id     = idx;
      query_pred   = points.point_predator;
      query_closed = 1'b0;
      for (i = 0; i < NEIGHBORS; i++) begin
        nearest[i] = '{sq_dist: far_sq, id: '0, valid: 1'b0};
      end
      return;
    end
    if (query_closed) return;
    if (points.point_alive && idx != query_id && int'(idx) < MAX_AGENTS) begin
      d = squared_distance(points.point_x, points.point_y);
      if (d < radius_sq && !query_pred && points.point_predator) begin
        expected_q.push_back('{kind: KIND_CRASH, rank: '0, id: idx, sq_dist: d,
                               valid: 1'b1, last: 1'b1});
        query_closed = 1'b1;
        return;
      end
      placed = 1'b0;
      for (j = 0; j < NEIGHBORS; j++) begin
        if (!placed && d < nearest[j].sq_dist) begin
          for (i = NEIGHBORS - 1; i > j; i--) begin
            nearest[i] = nearest[i-1];
          end
          nearest[j] = '{sq_dist: d, id: idx, valid: 1'b1};
          placed = 1'b1;
        end
      end
    end
    if (points.last_point) begin
      for (i = 0; i < NEIGHBORS; i++) begin
        expected_q.push_back('{kind: KIND_NEIGHBOR, rank: RANK_W'(i),
                               id: nearest[i].valid ? nearest[i].id : '0,
                               sq_dist: nearest[i].sq_dist, valid: nearest[i].valid,
                               last: (i == NEIGHBORS - 1)});
      end
      query_closed = 1'b1;
    end
  endfunction

  task automatic check_result();
    nn_result_t seen;
    nn_result_t want;
    seen = '{kind: results.kind, rank: results.rank, id: results.neighbor_index,
             sq_dist: results.dist_sq, valid: results.slot_valid,
             last: results.last_result};
    if (expected_q.size() == 0) begin
      report($sformatf("result beat with none expected: kind %0d rank %0d index %0d dist %0d",
                       seen.kind, seen.rank, seen.id, seen.sq_dist));
      return;
    end
    want = expected_q.pop_front();
    if (seen.kind !== want.kind)
      report($sformatf("kind got %0d expected %0d", seen.kind, want.kind));
    if (seen.rank !== want.rank)
      report($sformatf("rank got %0d expected %0d", seen.rank, want.rank));
    if (seen.id !== want.id)
      report($sformatf("neighbor_index got %0d expected %0d", seen.id, want.id));
    if (seen.sq_dist !== want.sq_dist)
      report($sformatf("dist_sq got %0d expected %0d", seen.sq_dist, want.sq_dist));
    if (seen.valid !== want.valid)
      report($sformatf("slot_valid got %0d expected %0d", seen.valid, want.valid));
    if (seen.last !== want.last)
      report($sformatf("last_result got %0d expected %0d", seen.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      radius_sq    = COLLISION_RADIUS_SQ_RESET;
      far_sq       = FAR_LIMIT_SQ_RESET;
      query_x      = '0;
      query_y      = '0;
      query_id     = '0;
      query_pred   = 1'b0;
      query_closed = 1'b1;
      for (int i = 0; i < NEIGHBORS; i++) nearest[i] = '0;
      expected_q.delete();
    end else begin
      if (results.valid && results.ready) check_result();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_COLLISION_RADIUS_SQ: radius_sq = cfg.data;
          REG_FAR_LIMIT_SQ: far_sq = cfg.data;
          default: ;
        endcase
      end
      if (points.valid && points.ready) take_point();
    end
    pending <= expected_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top: drives the point, result and register channels and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import nns_pkg::*;

  localparam int NEIGHBORS    = 5;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AFTER   = 60;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 20;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   long_hold_done = 0;

  nns_point_if  points ();
  nns_result_if results ();
  nns_cfg_if    cfg ();

  nearest_neighbor_select_collide #(.NEIGHBORS(NEIGHBORS)) dut (
    .clk(clk), .rst(rst), .points(points), .results(results), .cfg(cfg)
  );

  nns_checker #(.NEIGHBORS(NEIGHBORS)) check_results (
    .clk(clk), .rst(rst), .points(points), .results(results), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic send_point(input logic op, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [INDEX_W-1:0] idx, input logic alive,
                            input logic pred, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap != 0) begin
        points.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    points.valid          <= 1'b1;
    points.operation      <= op;
    points.point_x        <= x;
    points.point_y        <= y;
    points.point_index    <= idx;
    points.point_alive    <= alive;
    points.point_predator <= pred;
    points.last_point     <= last;
    do @(posedge clk); while (!points.ready);
    items_sent++;
  endtask

  task automatic query(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                       input logic [INDEX_W-1:0] idx, input logic pred);
    send_point(OP_QUERY, x, y, idx, 1'b1, pred, 1'b0);
  endtask

  task automatic cand(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                      input logic [INDEX_W-1:0] idx, input logic alive, input logic pred,
                      input logic last);
    send_point(OP_CANDIDATE, x, y, idx, alive, pred, last);
  endtask

  // The block may still be working on candidates after the last result beat.
  task automatic wait_idle();
    points.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input dist_t radius, input dist_t far);
    cfg.valid <= 1'b1;
    cfg.index <= REG_COLLISION_RADIUS_SQ;
    cfg.data  <= radius;
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= REG_FAR_LIMIT_SQ;
    cfg.data  <= far;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_query();
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [INDEX_W-1:0]        sid;
    logic [INDEX_W-1:0]        cid;
    int                        n;
    int                        spread;
    int                        off;
    bit                        abandon;
    sx = COORD_W'($urandom);
    sy = COORD_W'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      sx = sx >>> 3;
      sy = sy >>> 3;
    end
    case ($urandom_range(0, 3))
      0: spread = 7;
      1: spread = 10;
      2: spread = 12;
      default: spread = 16;
    endcase
    sid = INDEX_W'($urandom);
    send_point(OP_QUERY, sx, sy, sid, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
               1'($urandom_range(0, 1)));
    n = $urandom_range(1, 10);
    abandon = ($urandom_range(0, 19) == 0);
    for (int k = 1; k <= n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        cx = COORD_W'($urandom);
        cy = COORD_W'($urandom);
      end else begin
        off = int'($urandom) >>> (32 - spread);
        cx = sx + COORD_W'(off);
        off = int'($urandom) >>> (32 - spread);
        cy = sy + COORD_W'(off);
      end
      cid = ($urandom_range(0, 11) == 0) ? sid : INDEX_W'($urandom);
      cand(cx, cy, cid, ($urandom_range(0, 7) != 0), ($urandom_range(0, 3) == 0),
           (k == n && !abandon) || ($urandom_range(0, 29) == 0));
    end
    if ($urandom_range(0, 9) == 0)
      cand(COORD_W'($urandom), COORD_W'($urandom), INDEX_W'($urandom), 1'b1,
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(input dist_t radius, input dist_t far);
    int start;
    wait_idle();
    set_registers(radius, far);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) random_query();
  endtask

  initial begin
    int mode;
    int stretch;
    int tick;
    tick = 0;
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        long_hold_done = 1;
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(4, 40);
        repeat (stretch) begin
          case (mode)
            0: results.ready <= 1'b1;
            1: results.ready <= 1'($urandom_range(0, 1));
            2: results.ready <= ($urandom_range(0, 4) == 0);
            default: results.ready <= (tick % 3 != 0);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    points.valid          = 1'b0;
    points.operation      = OP_QUERY;
    points.point_x        = '0;
    points.point_y        = '0;
    points.point_index    = '0;
    points.point_alive    = 1'b0;
    points.point_predator = 1'b0;
    points.last_point     = 1'b0;
    cfg.valid             = 1'b0;
    cfg.index             = REG_COLLISION_RADIUS_SQ;
    cfg.data              = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Stray candidate with no query open, then a query whose flags must be ignored.
    cand(16'sd100, 16'sd100, 8'd7, 1'b1, 1'b0, 1'b1);
    send_point(OP_QUERY, 16'sd0, 16'sd0, 8'd10, 1'b0, 1'b0, 1'b1);
    cand(16'sd16, 16'sd0, 8'd10, 1'b1, 1'b0, 1'b0);
    cand(16'sd32, 16'sd0, 8'd11, 1'b0, 1'b0, 1'b0);
    cand(16'sd0, 16'sd400, 8'd12, 1'b1, 1'b1, 1'b0);
    cand(16'sd32767, -16'sd32768, 8'd13, 1'b1, 1'b0, 1'b0);
    cand(16'sd300, 16'sd0, 8'd14, 1'b1, 1'b0, 1'b0);
    cand(16'sd0, 16'sd300, 8'd15, 1'b1, 1'b0, 1'b0);
    cand(-16'sd100, 16'sd0, 8'd16, 1'b1, 1'b0, 1'b0);
    cand(16'sd50, 16'sd0, 8'd17, 1'b0, 1'b0, 1'b1);
    cand(16'sd20, 16'sd20, 8'd18, 1'b1, 1'b0, 1'b1);

    // Predator query fills the list and pushes the farthest entry out.
    send_point(OP_QUERY, -16'sd32768, 16'sd32767, 8'd200, 1'b1, 1'b1, 1'b1);
    cand(-16'sd32760, 16'sd32767, 8'd201, 1'b1, 1'b1, 1'b0);
    cand(-16'sd32368, 16'sd32767, 8'd202, 1'b1, 1'b0, 1'b0);
    cand(-16'sd32568, 16'sd32767, 8'd203, 1'b1, 1'b0, 1'b0);
    cand(-16'sd32668, 16'sd32767, 8'd204, 1'b1, 1'b1, 1'b0);
    cand(-16'sd32468, 16'sd32767, 8'd205, 1'b1, 1'b0, 1'b0);
    cand(-16'sd32718, 16'sd32767, 8'd255, 1'b1, 1'b0, 1'b1);

    // Crash against a close predator; the rest of the query is ignored.
    query(16'sd0, 16'sd0, 8'd1, 1'b0);
    cand(16'sd5, 16'sd5, 8'd2, 1'b1, 1'b0, 1'b0);
    cand(16'sd10, -16'sd10, 8'd3, 1'b1, 1'b1, 1'b0);
    cand(16'sd0, 16'sd0, 8'd4, 1'b1, 1'b0, 1'b1);

    // A new query abandons the open one; registers change in the middle of it.
    query(16'sd1000, 16'sd1000, 8'd50, 1'b0);
    cand(16'sd1010, 16'sd1000, 8'd51, 1'b1, 1'b0, 1'b0);
    query(16'sd0, 16'sd0, 8'd60, 1'b0);
    cand(16'sd10, 16'sd0, 8'd61, 1'b1, 1'b0, 1'b0);
    wait_idle();
    set_registers('0, 34'd100);
    cand(16'sd20, 16'sd0, 8'd62, 1'b1, 1'b1, 1'b0);
    cand(16'sd0, 16'sd5, 8'd63, 1'b1, 1'b0, 1'b1);

    random_phase('0, '1);
    random_phase('1, '0);
    random_phase(dist_t'($urandom_range(0, 1 << 18)), dist_t'($urandom_range(0, 1 << 28)));
    random_phase(COLLISION_RADIUS_SQ_RESET, FAR_LIMIT_SQ_RESET);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
